// ===== rtl/lrupr_pkg.sv =====
package lrupr_pkg;

    localparam int PAGE_W      = 16;
    localparam int CFG_W       = 4;
    localparam int FIDX_W      = 3;
    localparam int CNT_W       = 16;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;

    localparam int OFS_HIT     = 0;
    localparam int OFS_FIDX    = 1;
    localparam int OFS_EVV     = 4;
    localparam int OFS_EVP     = 5;
    localparam int OFS_CNT     = 21;

    localparam logic [CFG_W-1:0] CFG_FRAMES_RESET = 4'd8;

endpackage

// ===== rtl/lru_page_replacement_core.sv =====
// A page reference accepted at a clock edge shows its result word
// at the output from the next cycle on.
// Throughput: one reference per cycle while the output is not stalled; the tag compare, victim search and rank
// update for all frames sit between the frame registers and the result register.
// Reset (synchronous, active low) empties all frames, clears the fault counter
// and sets the active frame count to 8; no clearing pass is needed.
module lru_page_replacement_core #(
    parameter int FRAMES = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [lrupr_pkg::CFG_W-1:0]         i_cfg_wr_data,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // page[15:0]
    input  logic [lrupr_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // hit[0], frame_index[3:1], evicted_valid[4], evicted_page[20:5],
    // fault_count[36:21], zero fill[39:37]
    output logic [lrupr_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    import lrupr_pkg::*;

    localparam int IW = $clog2(FRAMES);
    localparam int RW = $clog2(FRAMES);
    localparam int FW = $clog2(FRAMES + 1);

    logic [PAGE_W-1:0]      r_frame_page [FRAMES];
    logic [FRAMES-1:0]      r_frame_valid;
    logic [RW-1:0]          r_rank [FRAMES];
    logic [FW-1:0]          r_filled;
    logic [CNT_W-1:0]       r_faults;
    logic [CFG_W-1:0]       r_frames_in_use;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [CNT_W-1:0]       n_faults;
    logic [OUT_TDATA_W-1:0] n_out_data;

    logic                   w_accept;
    logic [PAGE_W-1:0]      w_page;
    logic [FW-1:0]          w_active_n;
    logic [FRAMES-1:0]      w_act_valid;
    logic [FRAMES-1:0]      w_match;
    logic [FRAMES-1:0]      w_is_max;
    logic                   w_hit;
    logic [IW-1:0]          w_hit_idx;
    logic [IW-1:0]          w_victim_idx;
    logic                   w_fill;
    logic                   w_evict;
    logic [IW-1:0]          w_idx;
    logic [IW+2:0]          w_idx_ext;
    logic [FW-1:0]          w_old_rank;
    logic [PAGE_W-1:0]      w_ev_page;

    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign w_page          = i_s_axis_tdata[PAGE_W-1:0];

    // A count of zero manages one frame; anything above the built count manages all.
    always_comb begin
        if (r_frames_in_use == '0) begin
            w_active_n = FW'(1);
        end else if (int'(r_frames_in_use) > FRAMES) begin
            w_active_n = FW'(FRAMES);
        end else begin
            w_active_n = FW'(r_frames_in_use);
        end
    end

    always_comb begin
        for (int k = 0; k < FRAMES; k++) begin
            w_act_valid[k] = r_frame_valid[k] && (FW'(k) < w_active_n);
            w_match[k]     = w_act_valid[k] && (r_frame_page[k] == w_page);
        end
    end

    // Ranks of valid frames are distinct, so the oldest active frame is the one
    // that no other active frame outranks.
    always_comb begin
        for (int k = 0; k < FRAMES; k++) begin
            w_is_max[k] = w_act_valid[k];
            for (int j = 0; j < FRAMES; j++) begin
                if (w_act_valid[j] && (r_rank[j] > r_rank[k])) begin
                    w_is_max[k] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        w_hit_idx    = '0;
        w_victim_idx = '0;
        for (int k = FRAMES - 1; k >= 0; k--) begin
            if (w_match[k]) begin
                w_hit_idx = IW'(k);
            end
            if (w_is_max[k]) begin
                w_victim_idx = IW'(k);
            end
        end
    end

    assign w_hit   = |w_match;
    assign w_fill  = !w_hit && (r_filled < w_active_n);
    assign w_evict = !w_hit && !w_fill;

    always_comb begin
        if (w_hit) begin
            w_idx      = w_hit_idx;
            w_old_rank = FW'(r_rank[w_hit_idx]);
        end else if (w_fill) begin
            w_idx      = r_filled[IW-1:0];
            w_old_rank = r_filled;
        end else begin
            w_idx      = w_victim_idx;
            w_old_rank = FW'(r_rank[w_victim_idx]);
        end
    end

    assign w_idx_ext = (IW + 3)'(w_idx);
    assign w_ev_page = w_evict ? r_frame_page[w_victim_idx] : '0;

    always_comb begin
        n_faults = r_faults;
        if (!w_hit && (r_faults != '1)) begin
            n_faults = r_faults + CNT_W'(1);
        end
    end

    always_comb begin
        n_out_data                        = '0;
        n_out_data[OFS_HIT]               = w_hit;
        n_out_data[OFS_FIDX +: FIDX_W]    = w_idx_ext[FIDX_W-1:0];
        n_out_data[OFS_EVV]               = w_evict;
        n_out_data[OFS_EVP +: PAGE_W]     = w_ev_page;
        n_out_data[OFS_CNT +: CNT_W]      = n_faults;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_valid   <= '0;
            r_filled        <= '0;
            r_faults        <= '0;
            r_frames_in_use <= CFG_FRAMES_RESET;
            r_out_valid     <= 1'b0;
            for (int k = 0; k < FRAMES; k++) begin
                r_rank[k] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_frames_in_use <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept) begin
                r_faults <= n_faults;
                if (w_fill) begin
                    r_filled             <= r_filled + FW'(1);
                    r_frame_valid[w_idx] <= 1'b1;
                end
                for (int k = 0; k < FRAMES; k++) begin
                    if (IW'(k) == w_idx) begin
                        r_rank[k] <= '0;
                    end else if (r_frame_valid[k] && (FW'(r_rank[k]) < w_old_rank)) begin
                        r_rank[k] <= r_rank[k] + RW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
            if (!w_hit) begin
                r_frame_page[w_idx] <= w_page;
            end
        end
    end

endmodule

// ===== rtl/lrupr_checker.sv =====
module lrupr_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_s_axis_tready,
    input logic                                o_m_axis_tvalid,
    input logic                                i_m_axis_tready,
    input logic [lrupr_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    import lrupr_pkg::*;

    logic w_hit;
    logic w_evv;

    assign w_hit = o_m_axis_tdata[OFS_HIT];
    assign w_evv = o_m_axis_tdata[OFS_EVV];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("Result word changed while stalled.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("Result valid right after reset.");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_hit |-> !w_evv)
        else $error("Eviction reported on a hit.");

    a_evict_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !w_evv |-> (o_m_axis_tdata[OFS_EVP +: PAGE_W] == '0))
        else $error("Evicted page nonzero without an eviction.");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("Input stalled while the result register is empty.");

endmodule

bind lru_page_replacement_core lrupr_checker u_lrupr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import lrupr_pkg::*;

    localparam int NUM_FRAMES  = 8;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RAND_WORDS  = 1950;
    localparam int CALM_WORDS  = 200;
    localparam int SAT_WORDS   = 40;

    typedef enum logic [1:0] {
        REF_PAGE,
        REF_SETUP,
        REF_SETTLE
    } ref_kind_e;

    typedef struct {
        ref_kind_e           kind;
        logic [PAGE_W-1:0]   value;
        bit                  calm;
    } ref_item_t;

    typedef struct {
        logic                hit;
        logic [FIDX_W-1:0]   frame;
        logic                evicted;
        logic [PAGE_W-1:0]   victim;
        logic [CNT_W-1:0]    faults;
    } lru_result_t;

    logic                    i_clk;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]        i_cfg_wr_data = '0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    // page[15:0]
    logic [IN_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    // hit[0], frame_index[3:1], evicted_valid[4], evicted_page[20:5],
    // fault_count[36:21], zero fill[39:37]
    logic [OUT_TDATA_W-1:0]  o_m_axis_tdata;

    ref_item_t               ref_stream[$];
    lru_result_t             pending_results[$];

    logic [PAGE_W-1:0]       frame_pg[NUM_FRAMES];
    bit                      frame_vld[NUM_FRAMES];
    int                      frame_rank[NUM_FRAMES];
    int                      filled;
    logic [CNT_W-1:0]        fault_total;
    logic [CFG_W-1:0]        active_frames;

    int                      sent_cnt;
    int                      recv_cnt;
    int                      cycle_cnt = 0;
    bit                      calm = 1'b0;
    bit                      failed = 1'b0;

    lru_page_replacement_core #(
        .FRAMES(NUM_FRAMES)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void promote(input int idx, input int old_rank);
        for (int k = 0; k < NUM_FRAMES; k++) begin
            if (k != idx && frame_vld[k] && frame_rank[k] < old_rank) begin
                frame_rank[k]++;
            end
        end
        frame_rank[idx] = 0;
    endfunction

    function automatic lru_result_t lru_lookup(input logic [PAGE_W-1:0] page);
        lru_result_t r;
        int          n;
        int          idx;
        int          best;
        bit          found;
        r = '{default: '0};
        n = (active_frames == 0) ? 1 :
            (active_frames > NUM_FRAMES) ? NUM_FRAMES : int'(active_frames);
        idx = 0;
        best = 0;
        found = 1'b0;
        for (int k = 0; k < n; k++) begin
            if (!found && frame_vld[k] && frame_pg[k] == page) begin
                found = 1'b1;
                idx = k;
            end
        end
        if (found) begin
            r.hit = 1'b1;
            promote(idx, frame_rank[idx]);
        end else begin
            if (fault_total != '1) begin
                fault_total++;
            end
            if (filled < n) begin
                idx = filled;
                frame_pg[idx] = page;
                frame_vld[idx] = 1'b1;
                promote(idx, filled);
                filled++;
            end else begin
                // All active frames are filled, so the oldest one among them goes.
                for (int k = 0; k < n; k++) begin
                    if (frame_vld[k] && (!found || frame_rank[k] > best)) begin
                        best = frame_rank[k];
                        idx = k;
                        found = 1'b1;
                    end
                end
                r.evicted = 1'b1;
                r.victim = frame_pg[idx];
                frame_pg[idx] = page;
                promote(idx, best);
            end
        end
        r.frame = idx[FIDX_W-1:0];
        r.faults = fault_total;
        return r;
    endfunction

    function automatic void add_page(input logic [PAGE_W-1:0] page, input bit quiet = 1'b0);
        ref_stream.push_back('{REF_PAGE, page, quiet});
    endfunction

    function automatic void add_setup(input int frames);
        ref_stream.push_back('{REF_SETUP, PAGE_W'(frames), 1'b0});
    endfunction

    always @(posedge i_clk) begin : driver
        ref_item_t          head;
        logic               nxt_valid;
        logic [PAGE_W-1:0]  nxt_data;
        logic               nxt_cfg_en;
        int                 gap_left;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata <= '0;
            i_cfg_wr_en <= 1'b0;
            i_cfg_wr_data <= '0;
            gap_left = 0;
            sent_cnt = 0;
            filled = 0;
            fault_total = '0;
            active_frames = CFG_FRAMES_RESET;
            for (int k = 0; k < NUM_FRAMES; k++) begin
                frame_vld[k] = 1'b0;
                frame_rank[k] = 0;
                frame_pg[k] = '0;
            end
        end else begin
            nxt_valid = i_s_axis_tvalid;
            nxt_data = i_s_axis_tdata;
            nxt_cfg_en = 1'b0;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                pending_results.push_back(lru_lookup(i_s_axis_tdata));
                sent_cnt++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (ref_stream.size() > 0) begin
                    head = ref_stream[0];
                    calm <= head.calm;
                    case (head.kind)
                        REF_PAGE: begin
                            if (!head.calm && $urandom_range(0, 7) == 0) begin
                                gap_left = $urandom_range(0, 4);
                            end else begin
                                nxt_valid = 1'b1;
                                nxt_data = head.value;
                                void'(ref_stream.pop_front());
                            end
                        end
                        REF_SETUP: begin
                            if (sent_cnt == recv_cnt) begin
                                nxt_cfg_en = 1'b1;
                                i_cfg_wr_data <= head.value[CFG_W-1:0];
                                active_frames = head.value[CFG_W-1:0];
                                void'(ref_stream.pop_front());
                            end
                        end
                        REF_SETTLE: begin
                            if (sent_cnt == recv_cnt) begin
                                void'(ref_stream.pop_front());
                            end
                        end
                        default: begin
                            void'(ref_stream.pop_front());
                        end
                    endcase
                end
            end
            i_s_axis_tvalid <= nxt_valid;
            i_s_axis_tdata <= nxt_data;
            i_cfg_wr_en <= nxt_cfg_en;
        end
    end

    always @(posedge i_clk) begin : monitor
        lru_result_t want;
        lru_result_t got;
        int          stall_left;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            recv_cnt <= 0;
            stall_left = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                recv_cnt <= recv_cnt + 1;
                got.hit = o_m_axis_tdata[OFS_HIT];
                got.frame = o_m_axis_tdata[OFS_FIDX +: FIDX_W];
                got.evicted = o_m_axis_tdata[OFS_EVV];
                got.victim = o_m_axis_tdata[OFS_EVP +: PAGE_W];
                got.faults = o_m_axis_tdata[OFS_CNT +: CNT_W];
                if (pending_results.size() == 0) begin
                    $error("unexpected result word %h", o_m_axis_tdata);
                    failed = 1'b1;
                end else begin
                    want = pending_results.pop_front();
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d, actual %0d", want.hit, got.hit);
                        failed = 1'b1;
                    end
                    if (got.frame !== want.frame) begin
                        $error("frame_index: expected %0d, actual %0d", want.frame, got.frame);
                        failed = 1'b1;
                    end
                    if (got.evicted !== want.evicted) begin
                        $error("evicted_valid: expected %0d, actual %0d",
                               want.evicted, got.evicted);
                        failed = 1'b1;
                    end
                    if (got.victim !== want.victim) begin
                        $error("evicted_page: expected %h, actual %h", want.victim, got.victim);
                        failed = 1'b1;
                    end
                    if (got.faults !== want.faults) begin
                        $error("fault_count: expected %0d, actual %0d", want.faults, got.faults);
                        failed = 1'b1;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 4);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL lru_page_replacement_core");
            $finish;
        end
    end

    initial begin : stimulus
        int                 phase_frames[8];
        logic [PAGE_W-1:0]  pool[16];
        int                 n;
        int                 pool_len;
        int                 word_no;

        // A small active set first, then filling resumes when it grows.
        add_setup(2);
        add_page(16'h0000);
        add_page(16'hFFFF);
        add_page(16'h0000);
        add_page(16'h5A5A);
        add_setup(5);
        add_page(16'h0001);
        add_page(16'h0002);
        add_page(16'h0003);
        add_page(16'h0004);
        // Shrinking below the filled count leaves frames that are not matched.
        add_setup(3);
        add_page(16'h0003);
        add_setup(8);
        add_page(16'h0003);
        add_page(16'h00FF);
        add_page(16'h7F00);
        add_page(16'h8001);
        add_page(16'h1234);
        add_setup(0);
        add_page(16'h4444);
        add_page(16'h4444);
        add_page(16'h0000);
        add_setup(15);
        add_page(16'h0003);
        add_page(16'hFFFF);
        add_page(16'h8000);

        phase_frames = '{1, 8, 0, 15, 4, $urandom_range(2, 7), $urandom_range(9, 14), 8};
        word_no = 0;
        for (int p = 0; p < 8; p++) begin
            add_setup(phase_frames[p]);
            n = (phase_frames[p] == 0) ? 1 :
                (phase_frames[p] > NUM_FRAMES) ? NUM_FRAMES : phase_frames[p];
            pool_len = n + $urandom_range(0, 6);
            for (int k = 0; k < 16; k++) begin
                pool[k] = PAGE_W'($urandom_range(0, 65535));
            end
            for (int i = 0; i < RAND_WORDS / 8; i++) begin
                if (p == 4 && i == RAND_WORDS / 16) begin
                    ref_stream.push_back('{REF_SETTLE, '0, 1'b0});
                end
                if ($urandom_range(0, 7) == 0) begin
                    add_page(PAGE_W'($urandom_range(0, 65535)),
                             word_no >= RAND_WORDS - CALM_WORDS);
                end else begin
                    add_page(pool[$urandom_range(0, pool_len - 1)],
                             word_no >= RAND_WORDS - CALM_WORDS);
                end
                word_no++;
            end
        end

        // With one active frame every new page faults.
        add_setup(1);
        for (int i = 0; i < SAT_WORDS; i++) begin
            add_page(PAGE_W'(i), 1'b1);
        end
        add_page(16'h0ABC, 1'b1);
        add_page(16'h0ABC, 1'b1);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (ref_stream.size() != 0 || i_s_axis_tvalid || pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (!failed && pending_results.size() == 0) begin
            $display("PASS lru_page_replacement_core");
        end else begin
            $display("FAIL lru_page_replacement_core");
        end
        $finish;
    end

endmodule
